@@ rtl/core/msb_first_bit_packer_defines.svh @@
// Assertion macros used by the packer datapath.
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define MBP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("packer assertion failed");
`define MBP_ASSERT_IMP(lbl, ante, cons) \
    `MBP_ASSERT(lbl, (ante) |-> (cons))
`define MBP_ASSERT_NEXT(lbl, ante, cons) \
    `MBP_ASSERT(lbl, (ante) |=> (cons))
`else
`define MBP_ASSERT(lbl, prop)
`define MBP_ASSERT_IMP(lbl, ante, cons)
`define MBP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/mbp_pkg.sv @@
`default_nettype none

package mbp_pkg;

    localparam int BYTE_BITS = 8;

    // input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PACK,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic pack_step;
        logic flush_step;
    } dp_cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic pend_zero;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/mbp_dpath.sv @@
`default_nettype none

`include "msb_first_bit_packer_defines.svh"

module mbp_dpath #(
    parameter int MAX_FIELD_BITS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mbp_pkg::dp_cmd_t cmd,
    output mbp_pkg::dp_stat_t     stat,
    input  wire logic [63:0]      field_value,
    input  wire logic [6:0]       field_width,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  last_of_run
);
    import mbp_pkg::*;

    localparam int MB = MAX_FIELD_BITS;
    localparam int RW = $clog2(MB + 1);
    localparam int CW = (RW > 4) ? RW : 4;

    logic [MB-1:0] bits_reg, bits_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [7:0]    part_reg, part_next;
    logic [2:0]    pend_reg, pend_next;
    logic          oval_reg, oval_next;
    logic [7:0]    obyte_reg;
    logic          olast_reg;

    logic [RW-1:0]   w_sat;
    logic [RW-1:0]   sh_amt;
    logic [3:0]      room;
    logic [3:0]      take;
    logic [MB+7:0]   ext;
    logic [7:0]      top8;
    logic [7:0]      placed;
    logic [3:0]      fill;
    logic [RW-1:0]   rem_after;
    logic            out_free;
    logic            emit;
    logic [7:0]      emit_byte;
    logic            emit_last;

    // saturate width, left-align the field so its first bit sits at the top
    always_comb
    begin
        if (field_width > 7'(MB))
            w_sat = RW'(MB);
        else
            w_sat = RW'(field_width);
        sh_amt = RW'(MB) - w_sat;
    end

    // one pack step: move up to the free room of the pending byte
    always_comb
    begin
        room = 4'(BYTE_BITS) - {1'b0, pend_reg};
        if (CW'(rem_reg) < CW'(room))
            take = 4'(rem_reg);
        else
            take = room;
        ext       = {bits_reg, 8'b0};
        top8      = ext[MB+7 -: 8] & ~(8'hFF >> take);
        placed    = top8 >> pend_reg;
        fill      = {1'b0, pend_reg} + take;
        rem_after = rem_reg - RW'(take);
    end

    assign out_free = !oval_reg || !out_stall;

    always_comb
    begin
        bits_next = bits_reg;
        rem_next  = rem_reg;
        part_next = part_reg;
        pend_next = pend_reg;
        emit      = 1'b0;
        emit_byte = part_reg | placed;
        emit_last = 1'b1;
        if (cmd.load)
        begin
            bits_next = field_value[MB-1:0] << sh_amt;
            rem_next  = w_sat;
        end
        else if (cmd.pack_step)
        begin
            bits_next = bits_reg << take;
            rem_next  = rem_after;
            if (fill[3])
            begin
                emit      = 1'b1;
                emit_last = CW'(rem_after) < CW'(BYTE_BITS);
                part_next = 8'h00;
                pend_next = 3'd0;
            end
            else
            begin
                part_next = part_reg | placed;
                pend_next = fill[2:0];
            end
        end
        else if (cmd.flush_step)
        begin
            emit      = pend_reg != 3'd0;
            emit_byte = part_reg;
            part_next = 8'h00;
            pend_next = 3'd0;
        end
        oval_next = emit || (oval_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            part_reg <= 8'h00;
            pend_reg <= 3'd0;
            oval_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            part_reg <= part_next;
            pend_reg <= pend_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        if (emit)
        begin
            obyte_reg <= emit_byte;
            olast_reg <= emit_last;
        end
    end

    assign stat.rem_zero  = rem_reg == '0;
    assign stat.pend_zero = pend_reg == 3'd0;
    assign stat.out_free  = out_free;

    assign out_valid   = oval_reg;
    assign out_byte    = obyte_reg;
    assign last_of_run = olast_reg;

    `MBP_ASSERT_IMP(a_emit_into_free_slot, emit, out_free)
    `MBP_ASSERT_NEXT(a_flush_clears_pending, cmd.flush_step, pend_reg == 3'd0)
    `MBP_ASSERT(a_rem_in_range, CW'(rem_reg) <= CW'(MB))

endmodule

`default_nettype wire

@@ rtl/core/mbp_ctrl.sv @@
`default_nettype none

module mbp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              command,
    output logic                   in_stall,
    input  wire mbp_pkg::dp_stat_t stat,
    output mbp_pkg::dp_cmd_t       cmd
);
    import mbp_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (command == CMD_FLUSH)
                        state_next = ST_FLUSH;
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_PACK;
                    end
                end
            end
            ST_PACK:
            begin
                if (stat.rem_zero)
                    state_next = ST_IDLE;
                else if (stat.out_free)
                    cmd.pack_step = 1'b1;
            end
            ST_FLUSH:
            begin
                if (stat.pend_zero)
                    state_next = ST_IDLE;
                else if (stat.out_free)
                begin
                    cmd.flush_step = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/msb_first_bit_packer.sv @@
`default_nettype none

// MSB-first bit packer. A write item appends the low field_width bits of
// field_value (widths above MAX_FIELD_BITS saturate) to the pending byte,
// highest bit first, filling each byte from bit 7 down; every byte that fills
// comes out as one result item, and the last one of an item has last_of_run
// set. A flush item sends out the pending byte zero-padded if it holds any
// bits. Items are taken one at a time: a write item is accepted in idle,
// then takes one pack step per byte boundary or field end, and then the
// sequencer sees the field drained and returns to idle; a zero-width write
// takes no pack step. The pack step moves one chunk per cycle while the
// output register is free. A flush item is accepted in idle and then sends
// out the pending byte in one flush step if any bits are pending. A stalled
// output register holds the pack or flush step.
module msb_first_bit_packer #(
    parameter int MAX_FIELD_BITS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [63:0] field_value,
    input  wire logic [6:0]  field_width,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last_of_run
);
    import mbp_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer: accepts an item in idle, then drives the pack/flush steps
    mbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_stall (in_stall),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // field shift register, pending byte and the output register
    mbp_dpath #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .field_value (field_value),
        .field_width (field_width),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
